// File: sv/obbsat_pkg.sv
// ----------------------------------------------------------------------------
// obbsat_pkg
// Shared constants and a control type for the box separating axis tester.
// ----------------------------------------------------------------------------
package obbsat_pkg;

   localparam int NUM_AXES   = 15;
   localparam int NUM_DIMS   = 3;
   localparam int NUM_TERMS  = 6;   // three axes of each box
   localparam int DIST_SHIFT = 19;  // align centre distance with extent fraction
   localparam int FIELD_BITS = 63;
   localparam int NUM_FIELDS = 10;

   // load enables of the per-axis stages
   typedef struct packed {
      logic s2;
      logic s3;
      logic s4;
   } pipe_en_type;

endpackage

// File: sv/obbsat_axis.sv
// ----------------------------------------------------------------------------
// obbsat_axis
// Projection and separation check of both boxes on one candidate axis,
// three register stages: dot products, extent partial products, extent sum.
// ----------------------------------------------------------------------------
module obbsat_axis
   import obbsat_pkg::*;
#(
   parameter int CB = 21,
   localparam int AW = 2 * CB + 1
)(
   input  logic                 clock,
   input  pipe_en_type          pen,
   input  logic signed [AW-1:0] axis_in [NUM_DIMS],
   input  logic signed [CB:0]   d_in    [NUM_DIMS],
   input  logic signed [CB-1:0] ua_in   [NUM_DIMS][NUM_DIMS],
   input  logic signed [CB-1:0] ub_in   [NUM_DIMS][NUM_DIMS],
   input  logic signed [CB-1:0] ha_in   [NUM_DIMS],
   input  logic signed [CB-1:0] hb_in   [NUM_DIMS],
   output logic                 sep
);

   localparam int PW = CB + AW + 2;         // box axis dot product
   localparam int DW = CB + 1 + AW + 2;     // centre distance dot product
   localparam int LH = PW / 2;
   localparam int HH = PW - LH;
   localparam int TW = PW + CB;             // one extent term magnitude
   localparam int EW = TW + 4;              // signed sum of six terms
   localparam int DS = DW + DIST_SHIFT;
   localparam int CW = (DS > EW) ? DS : EW;

   // stage 2
   logic signed [PW-1:0] dot_in  [NUM_TERMS];
   logic signed [PW-1:0] dot_ff  [NUM_TERMS];
   logic signed [CB-1:0] h_in    [NUM_TERMS];
   logic signed [CB-1:0] h_ff    [NUM_TERMS];
   logic signed [DW-1:0] dist_in;
   logic signed [DW-1:0] dist_ff;
   logic                 zero_in;
   logic                 zero_ff;
   // stage 3
   logic [LH+CB-1:0]     pplo_in [NUM_TERMS];
   logic [LH+CB-1:0]     pplo_ff [NUM_TERMS];
   logic [HH+CB-1:0]     pphi_in [NUM_TERMS];
   logic [HH+CB-1:0]     pphi_ff [NUM_TERMS];
   logic [NUM_TERMS-1:0] hneg_in;
   logic [NUM_TERMS-1:0] hneg_ff;
   logic [DW-1:0]        mdist_in;
   logic [DW-1:0]        mdist_ff;
   logic                 zero3_ff;
   // stage 4
   logic signed [EW-1:0] ext_in;
   logic signed [EW-1:0] ext_ff;
   logic [DS-1:0]        sdist_ff;
   logic                 zero4_ff;

   always_comb begin
      logic signed [PW-1:0] acc;
      logic signed [DW-1:0] dacc;
      logic signed [CB-1:0] u;
      for (int t = 0; t < NUM_TERMS; t++) begin
         acc = '0;
         for (int k = 0; k < NUM_DIMS; k++) begin
            u = (t < NUM_DIMS) ? ua_in[t % NUM_DIMS][k] : ub_in[t % NUM_DIMS][k];
            acc = acc + PW'(u) * PW'(axis_in[k]);
         end
         dot_in[t] = acc;
         h_in[t]   = (t < NUM_DIMS) ? ha_in[t % NUM_DIMS] : hb_in[t % NUM_DIMS];
      end
      dacc = '0;
      for (int k = 0; k < NUM_DIMS; k++) begin
         dacc = dacc + DW'(d_in[k]) * DW'(axis_in[k]);
      end
      dist_in = dacc;
      zero_in = (axis_in[0] == '0) && (axis_in[1] == '0) && (axis_in[2] == '0);
   end

   always_ff @(posedge clock) begin
      if (pen.s2) begin
         dot_ff  <= dot_in;
         h_ff    <= h_in;
         dist_ff <= dist_in;
         zero_ff <= zero_in;
      end
   end

   // split the magnitude so that each multiplier stays narrow
   always_comb begin
      logic [PW-1:0] mag;
      logic [CB-1:0] habs;
      for (int t = 0; t < NUM_TERMS; t++) begin
         mag        = dot_ff[t][PW-1] ? PW'(-dot_ff[t]) : PW'(dot_ff[t]);
         habs       = h_ff[t][CB-1] ? CB'(-h_ff[t]) : CB'(h_ff[t]);
         hneg_in[t] = h_ff[t][CB-1];
         pplo_in[t] = (LH+CB)'(mag[LH-1:0]) * (LH+CB)'(habs);
         pphi_in[t] = (HH+CB)'(mag[PW-1:LH]) * (HH+CB)'(habs);
      end
      mdist_in = dist_ff[DW-1] ? DW'(-dist_ff) : DW'(dist_ff);
   end

   always_ff @(posedge clock) begin
      if (pen.s3) begin
         pplo_ff  <= pplo_in;
         pphi_ff  <= pphi_in;
         hneg_ff  <= hneg_in;
         mdist_ff <= mdist_in;
         zero3_ff <= zero_ff;
      end
   end

   always_comb begin
      logic [TW-1:0]        term;
      logic signed [EW-1:0] st;
      logic signed [EW-1:0] acc;
      acc = '0;
      for (int t = 0; t < NUM_TERMS; t++) begin
         term = TW'(pplo_ff[t]) + (TW'(pphi_ff[t]) << LH);
         st   = $signed(EW'(term));
         acc  = hneg_ff[t] ? acc - st : acc + st;
      end
      ext_in = acc;
   end

   always_ff @(posedge clock) begin
      if (pen.s4) begin
         ext_ff   <= ext_in;
         sdist_ff <= {mdist_ff, {DIST_SHIFT{1'b0}}};
         zero4_ff <= zero3_ff;
      end
   end

   // a negative extent is beaten by any distance
   assign sep = !zero4_ff &&
                (ext_ff[EW-1] || (CW'(sdist_ff) > CW'($unsigned(ext_ff))));

endmodule

// File: sv/obb_obb_separating_axis_test_top.sv
// ----------------------------------------------------------------------------
// obb_obb_separating_axis_test_top
// Oriented box pair overlap test over fifteen candidate axes.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one box pair per request: ten 63-bit fields packed in
//   req_tdata, each holding three signed components of COMPONENT_BITS bits.
//   rsp_* returns one result per request, the collide bit in rsp_tdata[0].
//   From acceptance to rsp_tvalid a request passes the registered stages
//   for cross products, dot products, extent partial products, extent sums,
//   then the compare and reduction over all fifteen axes into the output
//   register. Throughput is one request per cycle while rsp_tready is high;
//   each stage holds its own valid bit and loads whenever it is empty or
//   the next stage moves, so bubbles are squeezed out and requests are
//   taken while a result waits. When rsp_tready is low the output holds;
//   req_tready drops only once every stage is full.
//   Reset clears the valid bits; the pipeline is empty and ready after it.
// ----------------------------------------------------------------------------
module obb_obb_separating_axis_test_top
   import obbsat_pkg::*;
#(
   parameter int COMPONENT_BITS = 21
)(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // a_center, a_axis_0, a_axis_1, a_axis_2, a_half_size,
   // b_center, b_axis_0, b_axis_1, b_axis_2, b_half_size (63 bits each)
   input  logic [631:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // collide
   output logic [7:0]   rsp_tdata
);

   localparam int CB = COMPONENT_BITS;
   localparam int AW = 2 * CB + 1;

   logic [5:1]  valid_ff;
   logic [5:1]  en;
   pipe_en_type pen;

   logic signed [CB-1:0] ua_in [NUM_DIMS][NUM_DIMS];
   logic signed [CB-1:0] ub_in [NUM_DIMS][NUM_DIMS];
   logic signed [CB-1:0] ha_in [NUM_DIMS];
   logic signed [CB-1:0] hb_in [NUM_DIMS];
   logic signed [CB:0]   d_in  [NUM_DIMS];
   logic signed [AW-1:0] axes_in [NUM_AXES][NUM_DIMS];

   logic signed [CB-1:0] ua_ff [NUM_DIMS][NUM_DIMS];
   logic signed [CB-1:0] ub_ff [NUM_DIMS][NUM_DIMS];
   logic signed [CB-1:0] ha_ff [NUM_DIMS];
   logic signed [CB-1:0] hb_ff [NUM_DIMS];
   logic signed [CB:0]   d_ff  [NUM_DIMS];
   logic signed [AW-1:0] axes_ff [NUM_AXES][NUM_DIMS];

   logic [NUM_AXES-1:0]  sep;
   logic                 collide_ff;

   // stage enables: load when empty or when the next stage moves
   assign en[5]      = !valid_ff[5] || rsp_tready;
   assign en[4]      = !valid_ff[4] || en[5];
   assign en[3]      = !valid_ff[3] || en[4];
   assign en[2]      = !valid_ff[2] || en[3];
   assign en[1]      = !valid_ff[1] || en[2];
   assign req_tready = en[1];
   assign pen        = '{s2: en[2], s3: en[3], s4: en[4]};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (en[1]) begin
            valid_ff[1] <= req_tvalid;
         end
         for (int s = 2; s <= 5; s++) begin
            if (en[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   // unpack the request and form the cross product axes
   always_comb begin
      logic signed [CB-1:0] ca;
      logic signed [CB-1:0] cb;
      for (int k = 0; k < NUM_DIMS; k++) begin
         ca = req_tdata[0*FIELD_BITS + k*CB +: CB];
         cb = req_tdata[5*FIELD_BITS + k*CB +: CB];
         d_in[k]  = (CB+1)'(cb) - (CB+1)'(ca);
         ha_in[k] = req_tdata[4*FIELD_BITS + k*CB +: CB];
         hb_in[k] = req_tdata[9*FIELD_BITS + k*CB +: CB];
         for (int i = 0; i < NUM_DIMS; i++) begin
            ua_in[i][k] = req_tdata[(1+i)*FIELD_BITS + k*CB +: CB];
            ub_in[i][k] = req_tdata[(6+i)*FIELD_BITS + k*CB +: CB];
         end
      end
      for (int i = 0; i < NUM_DIMS; i++) begin
         for (int k = 0; k < NUM_DIMS; k++) begin
            axes_in[i][k]          = AW'(ua_in[i][k]);
            axes_in[NUM_DIMS+i][k] = AW'(ub_in[i][k]);
         end
         for (int j = 0; j < NUM_DIMS; j++) begin
            axes_in[2*NUM_DIMS + i*NUM_DIMS + j][0] =
               AW'(ua_in[i][1]) * AW'(ub_in[j][2]) - AW'(ua_in[i][2]) * AW'(ub_in[j][1]);
            axes_in[2*NUM_DIMS + i*NUM_DIMS + j][1] =
               AW'(ua_in[i][2]) * AW'(ub_in[j][0]) - AW'(ua_in[i][0]) * AW'(ub_in[j][2]);
            axes_in[2*NUM_DIMS + i*NUM_DIMS + j][2] =
               AW'(ua_in[i][0]) * AW'(ub_in[j][1]) - AW'(ua_in[i][1]) * AW'(ub_in[j][0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         ua_ff   <= ua_in;
         ub_ff   <= ub_in;
         ha_ff   <= ha_in;
         hb_ff   <= hb_in;
         d_ff    <= d_in;
         axes_ff <= axes_in;
      end
   end

   for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
      obbsat_axis #(.CB(CB)) u_axis (
         .clock   (clock),
         .pen     (pen),
         .axis_in (axes_ff[g]),
         .d_in    (d_ff),
         .ua_in   (ua_ff),
         .ub_in   (ub_ff),
         .ha_in   (ha_ff),
         .hb_in   (hb_ff),
         .sep     (sep[g])
      );
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         collide_ff <= ~|sep;
      end
   end

   assign rsp_tvalid = valid_ff[5];
   assign rsp_tdata  = {7'b0, collide_ff};

`ifndef SYNTHESIS
   a_full_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (valid_ff == '1))
      else $error("request blocked with an empty stage");

   a_hold_stage1: assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && !en[2] |=> valid_ff[1])
      else $error("stage 1 request dropped while stalled");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !valid_ff[4] |=> !rsp_tvalid)
      else $error("result repeated after delivery");
`endif

endmodule

// File: tb/obb_obb_separating_axis_test_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// obb_obb_separating_axis_test_checker
// Watches both channels, predicts the collide bit of every accepted request
// with exact wide arithmetic and compares each response in order.
// ----------------------------------------------------------------------------
module obb_obb_separating_axis_test_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [631:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [7:0]   rsp_tdata,
   output int           fail_count,
   output int           pending_count
);

   typedef logic signed [127:0] wide_t;

   localparam int WANT_DEPTH = 4096;

   logic [7:0] want_mem [WANT_DEPTH];
   int         wr_count = 0;
   int         rd_count = 0;

   function automatic wide_t dot_product(input wide_t p [3], input wide_t q [3]);
      return p[0] * q[0] + p[1] * q[1] + p[2] * q[2];
   endfunction

   function automatic wide_t magnitude(input wide_t x);
      return (x < 0) ? -x : x;
   endfunction

   function automatic logic boxes_overlap(input logic [631:0] pair);
      wide_t comp [10][3];
      wide_t axis [15][3];
      wide_t ua [3][3];
      wide_t ub [3][3];
      wide_t delta [3];
      wide_t centre_gap;
      wide_t extent;
      int n;
      n = 0;
      for (int f = 0; f < 10; f++)
         for (int c = 0; c < 3; c++)
            comp[f][c] = $signed(pair[63 * f + 21 * c +: 21]);
      for (int i = 0; i < 3; i++) begin
         ua[i] = comp[1 + i];
         ub[i] = comp[6 + i];
         delta[i] = comp[5][i] - comp[0][i];
      end
      for (int i = 0; i < 3; i++) begin
         axis[n++] = ua[i];
         axis[n++] = ub[i];
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++) begin
            axis[n][0] = ua[i][1] * ub[j][2] - ua[i][2] * ub[j][1];
            axis[n][1] = ua[i][2] * ub[j][0] - ua[i][0] * ub[j][2];
            axis[n][2] = ua[i][0] * ub[j][1] - ua[i][1] * ub[j][0];
            n++;
         end
      for (int k = 0; k < 15; k++) begin
         // a degenerate axis cannot separate
         if (axis[k][0] == 0 && axis[k][1] == 0 && axis[k][2] == 0)
            continue;
         centre_gap = magnitude(dot_product(delta, axis[k])) <<< 19;
         extent = 0;
         for (int i = 0; i < 3; i++)
            extent += magnitude(dot_product(ua[i], axis[k])) * comp[4][i]
                    + magnitude(dot_product(ub[i], axis[k])) * comp[9][i];
         if (centre_gap > extent)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   assign pending_count = wr_count - rd_count;

   initial fail_count = 0;

   always @(posedge clock) begin
      logic [7:0] want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            want_mem[wr_count % WANT_DEPTH] = {7'd0, boxes_overlap(req_tdata)};
            wr_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (wr_count == rd_count) begin
               $display("%t: unexpected response, expected none, actual %h", $time, rsp_tdata);
               fail_count++;
            end else begin
               want = want_mem[rd_count % WANT_DEPTH];
               rd_count++;
               if (rsp_tdata !== want) begin
                  $display("%t: collide mismatch, expected %h, actual %h",
                           $time, want, rsp_tdata);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

// File: tb/obb_obb_separating_axis_test_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// obb_obb_separating_axis_test_top_tb
// Drives box pairs into the separating axis tester with random idling on
// both sides; the checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module obb_obb_separating_axis_test_top_tb;

   localparam int RANDOM_REQUESTS = 1600;
   localparam int QUIET_TAIL      = 200;
   localparam int STALL_LIMIT     = 5000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [631:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [7:0]   rsp_tdata;
   int           fail_count;
   int           pending_count;
   logic         quiet = 1'b0;
   int           idle_pct = 0;
   int           stall_left = 0;
   int           dead_cycles = 0;

   always #1 clock = ~clock;

   obb_obb_separating_axis_test_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   obb_obb_separating_axis_test_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // receiver back-pressure, rate changes now and then
   always @(posedge clock) begin
      if ($urandom_range(0, 255) == 0)
         idle_pct = $urandom_range(0, 2) * 15;
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
         stall_left = $urandom_range(0, 15);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         dead_cycles = 0;
      else if (!reset)
         dead_cycles++;
      if (dead_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   function automatic logic [62:0] vec3(input int x, input int y, input int z);
      return {z[20:0], y[20:0], x[20:0]};
   endfunction

   function automatic logic [631:0] box_pair(
      input logic [62:0] ca, a0, a1, a2, ha, cb, b0, b1, b2, hb);
      return {hb, b2, b1, b0, cb, ha, a2, a1, a0, ca};
   endfunction

   function automatic int rand_signed(input int span);
      return $urandom_range(0, 2 * span) - span;
   endfunction

   // well-formed pair: axes of moderate length, centres close enough to vary the answer
   function automatic logic [631:0] plausible_pair();
      logic [62:0] f [10];
      int one;
      for (int k = 0; k < 10; k++) begin
         if (k == 0 || k == 5)
            f[k] = vec3(rand_signed(6000), rand_signed(6000), rand_signed(6000));
         else if (k == 4 || k == 9)
            f[k] = vec3($urandom_range(0, 4000), $urandom_range(0, 4000),
                        $urandom_range(0, 4000));
         else if ($urandom_range(0, 3) == 0) begin
            one = $urandom_range(0, 1) ? 524287 : -524288;
            case ((k - 1) % 5)
               0: f[k] = vec3(one, 0, 0);
               1: f[k] = vec3(0, one, 0);
               default: f[k] = vec3(0, 0, one);
            endcase
         end else
            f[k] = vec3(rand_signed(524288), rand_signed(524288), rand_signed(524288));
      end
      return box_pair(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9]);
   endfunction

   task automatic send_request(input logic [631:0] pair);
      req_tvalid <= 1'b1;
      req_tdata  <= pair;
      do @(posedge clock); while (!req_tready);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   initial begin
      logic [62:0] ux, uy, uz, h1;
      logic [631:0] raw;
      logic [31:0] word;
      ux = vec3(524287, 0, 0);
      uy = vec3(0, 524287, 0);
      uz = vec3(0, 0, 524287);
      h1 = vec3(1024, 1024, 1024);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // all zero, all one, identical boxes
      send_request('0);
      send_request({632{1'b1}});
      send_request(box_pair('0, ux, uy, uz, h1, '0, ux, uy, uz, h1));
      // far apart along x, then just clear, then one step further
      send_request(box_pair('0, ux, uy, uz, h1, vec3(8000, 0, 0), ux, uy, uz, h1));
      send_request(box_pair('0, ux, uy, uz, h1, vec3(2048, 0, 0), ux, uy, uz, h1));
      send_request(box_pair('0, ux, uy, uz, h1, vec3(2049, 0, 0), ux, uy, uz, h1));
      // zero axes everywhere
      send_request(box_pair('0, '0, '0, '0, h1, vec3(9000, 9000, 0), '0, '0, '0, h1));
      // negative half size shrinks the extent
      send_request(box_pair('0, ux, uy, uz, vec3(-1024, 1024, 1024),
                            vec3(1500, 0, 0), ux, uy, uz, h1));
      // rotated box B, non-unit axes
      send_request(box_pair('0, ux, uy, uz, h1, vec3(2500, 2500, 0),
                            vec3(370727, 370727, 0), vec3(-370727, 370727, 0), uz, h1));
      send_request(box_pair(vec3(-1048576, -1048576, -1048576), vec3(-1048576, 1048575, 0),
                            uy, vec3(1048575, 1048575, 1048575),
                            vec3(1048575, 1048575, 1048575),
                            vec3(1048575, 1048575, 1048575), ux,
                            vec3(-1048576, -1048576, -1048576), uz,
                            vec3(-1048576, 0, 1048575)));

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n == RANDOM_REQUESTS / 2) begin
            // drain before going on
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_count != 0) @(posedge clock);
         end
         if (n == RANDOM_REQUESTS - QUIET_TAIL)
            quiet = 1'b1;
         if ($urandom_range(0, 4) == 0) begin
            for (int w = 0; w < 19; w++)
               raw[32 * w +: 32] = $urandom;
            word = $urandom;
            raw[631:608] = word[23:0];
            send_request(raw);
         end else
            send_request(plausible_pair());
      end
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// File: sim.f
sv/obbsat_pkg.sv
sv/obbsat_axis.sv
sv/obb_obb_separating_axis_test_top.sv
tb/obb_obb_separating_axis_test_checker.sv
tb/obb_obb_separating_axis_test_top_tb.sv
